// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/rtch_pkg.sv =====
// Package for the ray/triangle closest-hit core: widths, register indexes.
// No dependencies.
package rtch_pkg;
    localparam int CoordWidth  = 32;
    localparam int FaceIdWidth = 16;
    localparam int FracBits    = 16;
    localparam int CfgIdxWidth = 3;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5
    } cfg_idx_t;
endpackage

// ===== rtl/ray_triangle_closest_hit_core.sv =====
// Top level of the ray/triangle closest-hit core (Cramer's rule).
// Uses rtch_pkg and rtch_serial_mul.
//
// One ray is held in six configuration registers; triangles arrive as words
// on the s_axis side and each produces exactly one result word on m_axis.
// Each word's work is sequential: edge vectors are formed, then a shared
// bit-serial multiplier builds twelve 2x2 minors (two products each) and twelve
// 3x3 terms, 36 products in all. Each product steps through the W+1 multiplier
// bits. A restoring divider then produces t one quotient bit per cycle over
// the full 3W+22 bit dividend. The serial multiplier dominates the time of
// an item; a word that fails the sign tests skips the divider. A new word is
// accepted only in the idle state and only once the output register is empty
// or being read in that same cycle.
module ray_triangle_closest_hit_core #(
    parameter int COORD_WIDTH   = rtch_pkg::CoordWidth,
    parameter int FACE_ID_WIDTH = rtch_pkg::FaceIdWidth
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [rtch_pkg::CfgIdxWidth-1:0] cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, face_id (low bit up), zero fill
    input  logic [((9*COORD_WIDTH+FACE_ID_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // new_ray
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // best_t, best_face (low bit up), zero fill
    output logic [((COORD_WIDTH+FACE_ID_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // hit
    output logic m_axis_tuser
);
    import rtch_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int FW  = FACE_ID_WIDTH;
    localparam int EW  = W + 1;           // edge vector
    localparam int MW  = 2 * EW + 1;      // 2x2 minor
    localparam int DW  = EW + MW + 2;     // 3x3 determinant
    localparam int NW  = DW + FracBits;   // scaled dividend
    localparam int OW  = ((W + FW + 7) / 8) * 8;
    localparam int QCW = $clog2(NW + 1);
    localparam logic [W-1:0] TMax = {1'b0, {(W-1){1'b1}}};

    typedef enum logic [3:0] {
        ST_IDLE, ST_EDGE, ST_MINOR, ST_MINOR_W, ST_DET, ST_DET_W,
        ST_SIGN, ST_DIV, ST_DONE
    } state_t;

    state_t state_reg;
    logic signed [W-1:0] org_reg [3];
    logic signed [W-1:0] dir_reg [3];
    logic signed [W-1:0] va_reg [3];
    logic signed [W-1:0] vb_reg [3];
    logic signed [W-1:0] vc_reg [3];
    logic [FW-1:0] face_reg;
    logic          newray_reg;
    // columns: 0 e1, 1 e2, 2 s, 3 d
    logic signed [EW-1:0] col_reg [4][3];
    logic signed [MW-1:0] minor_reg [4][3];  // per determinant: m1 m2 m3
    logic signed [DW-1:0] det_reg [4];       // A T B G
    logic [3:0]  step_reg;
    logic [1:0]  sub_reg;
    logic signed [DW-1:0] acc_reg;
    logic [W-1:0]  closest_t_reg;
    logic [FW-1:0] closest_face_reg;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   rem_reg;
    logic [NW-1:0] quo_reg;
    logic [QCW-1:0] qcnt_reg;
    logic          out_valid_reg;
    logic          out_hit_reg;
    logic [W-1:0]  out_t_reg;
    logic [FW-1:0] out_face_reg;

    // determinant k uses columns (p,q,s)
    function automatic logic [1:0] col_of(input logic [1:0] k, input logic [1:0] pos);
        logic [1:0] r;
        begin
            case ({k, pos})
                4'b00_00: r = 2'd0; 4'b00_01: r = 2'd1; 4'b00_10: r = 2'd3;
                4'b01_00: r = 2'd0; 4'b01_01: r = 2'd1; 4'b01_10: r = 2'd2;
                4'b10_00: r = 2'd2; 4'b10_01: r = 2'd1; 4'b10_10: r = 2'd3;
                4'b11_00: r = 2'd0; 4'b11_01: r = 2'd2; 4'b11_10: r = 2'd3;
                default:  r = 2'd0;
            endcase
            col_of = r;
        end
    endfunction

    // shared multiplier operands
    logic mul_start, mul_done;
    logic signed [MW-1:0] mul_a;
    logic signed [EW-1:0] mul_b;
    logic signed [MW+EW-1:0] mul_p;
    logic [1:0] kk, mm;
    logic [1:0] cp, cq, cs;

    assign kk = step_reg[3:2];
    assign mm = step_reg[1:0];
    assign cp = col_of(kk, 2'd0);
    assign cq = col_of(kk, 2'd1);
    assign cs = col_of(kk, 2'd2);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_MINOR)
        begin
            // m1 = q.y s.z - q.z s.y ; m2 = p.y s.z - p.z s.y ; m3 = p.y q.z - p.z q.y
            case ({mm, sub_reg[0]})
                3'b00_0: begin mul_a = MW'(col_reg[cq][1]); mul_b = col_reg[cs][2]; end
                3'b00_1: begin mul_a = MW'(col_reg[cq][2]); mul_b = col_reg[cs][1]; end
                3'b01_0: begin mul_a = MW'(col_reg[cp][1]); mul_b = col_reg[cs][2]; end
                3'b01_1: begin mul_a = MW'(col_reg[cp][2]); mul_b = col_reg[cs][1]; end
                3'b10_0: begin mul_a = MW'(col_reg[cp][1]); mul_b = col_reg[cq][2]; end
                3'b10_1: begin mul_a = MW'(col_reg[cp][2]); mul_b = col_reg[cq][1]; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
        else
        begin
            case (mm)
                2'd0:    begin mul_a = minor_reg[kk][0]; mul_b = col_reg[cp][0]; end
                2'd1:    begin mul_a = minor_reg[kk][1]; mul_b = col_reg[cq][0]; end
                2'd2:    begin mul_a = minor_reg[kk][2]; mul_b = col_reg[cs][0]; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    assign mul_start = (state_reg == ST_MINOR) || (state_reg == ST_DET);

    rtch_serial_mul #(.AW(MW), .BW(EW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    // sign-normalized determinants and hit tests
    logic          a_neg;
    logic [DW-1:0] abs_a;
    logic signed [DW-1:0] nt, nb, ng;
    logic signed [DW+1:0] bg_slack;
    logic          pre_ok;
    logic [DW:0]   rem_sh;
    logic [DW+1:0] rem_try;
    logic [W-1:0]  tq;
    logic          tbig;

    assign a_neg  = det_reg[0][DW-1];
    assign abs_a  = a_neg ? DW'(-det_reg[0]) : DW'(det_reg[0]);
    assign nt     = a_neg ? -det_reg[1] : det_reg[1];
    assign nb     = a_neg ? -det_reg[2] : det_reg[2];
    assign ng     = a_neg ? -det_reg[3] : det_reg[3];
    assign bg_slack = (DW+2)'($signed(abs_a)) - (DW+2)'(nb) - (DW+2)'(ng);
    assign pre_ok = (det_reg[0] != '0) && !nt[DW-1] && (nt != '0) && !nb[DW-1]
                    && !ng[DW-1] && !bg_slack[DW+1];
    assign rem_sh  = {rem_reg[DW-1:0], num_reg[NW-1]};
    assign rem_try = (DW+2)'(rem_sh) - (DW+2)'(den_reg);
    assign tbig    = (quo_reg[NW-1:W-1] != '0);
    assign tq      = tbig ? TMax : quo_reg[W-1:0];

    logic [W-1:0] cur_best;
    assign cur_best = newray_reg ? TMax : closest_t_reg;

    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            org_reg[0] <= '0; org_reg[1] <= '0; org_reg[2] <= '0;
            dir_reg[0] <= '0; dir_reg[1] <= '0;
            dir_reg[2] <= W'(1) << FracBits;
            closest_t_reg    <= TMax;
            closest_face_reg <= '0;
            out_valid_reg    <= 1'b0;
            step_reg         <= '0;
            sub_reg          <= '0;
            qcnt_reg         <= '0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready && state_reg != ST_DONE)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_ORIGIN_X: org_reg[0] <= cfg_data;
                    REG_ORIGIN_Y: org_reg[1] <= cfg_data;
                    REG_ORIGIN_Z: org_reg[2] <= cfg_data;
                    REG_DIR_X:    dir_reg[0] <= cfg_data;
                    REG_DIR_Y:    dir_reg[1] <= cfg_data;
                    REG_DIR_Z:    dir_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            va_reg[i] <= s_axis_tdata[i*W +: W];
                            vb_reg[i] <= s_axis_tdata[(3+i)*W +: W];
                            vc_reg[i] <= s_axis_tdata[(6+i)*W +: W];
                        end
                        face_reg   <= s_axis_tdata[9*W +: FW];
                        newray_reg <= s_axis_tuser;
                        state_reg  <= ST_EDGE;
                    end
                end
                ST_EDGE:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        col_reg[0][i] <= EW'(va_reg[i]) - EW'(vb_reg[i]);
                        col_reg[1][i] <= EW'(va_reg[i]) - EW'(vc_reg[i]);
                        col_reg[2][i] <= EW'(va_reg[i]) - EW'(org_reg[i]);
                        col_reg[3][i] <= EW'(dir_reg[i]);
                    end
                    step_reg  <= '0;
                    sub_reg   <= '0;
                    state_reg <= ST_MINOR;
                end
                ST_MINOR: state_reg <= ST_MINOR_W;
                ST_MINOR_W:
                begin
                    if (mul_done)
                    begin
                        if (sub_reg[0] == 1'b0)
                        begin
                            acc_reg   <= DW'(mul_p);
                            sub_reg   <= 2'd1;
                            state_reg <= ST_MINOR;
                        end
                        else
                        begin
                            minor_reg[kk][mm] <= MW'(acc_reg - DW'(mul_p));
                            sub_reg <= '0;
                            if (mm == 2'd2)
                            begin
                                if (kk == 2'd3)
                                begin
                                    step_reg  <= '0;
                                    state_reg <= ST_DET;
                                end
                                else
                                begin
                                    step_reg  <= {kk + 2'd1, 2'd0};
                                    state_reg <= ST_MINOR;
                                end
                            end
                            else
                            begin
                                step_reg  <= step_reg + 4'd1;
                                state_reg <= ST_MINOR;
                            end
                        end
                    end
                end
                ST_DET: state_reg <= ST_DET_W;
                ST_DET_W:
                begin
                    if (mul_done)
                    begin
                        // det = p.x m1 - q.x m2 + s.x m3
                        case (mm)
                            2'd0:    acc_reg <= DW'(mul_p);
                            2'd1:    acc_reg <= acc_reg - DW'(mul_p);
                            default: acc_reg <= acc_reg + DW'(mul_p);
                        endcase
                        if (mm == 2'd2)
                        begin
                            det_reg[kk] <= acc_reg + DW'(mul_p);
                            if (kk == 2'd3)
                                state_reg <= ST_SIGN;
                            else
                            begin
                                step_reg  <= {kk + 2'd1, 2'd0};
                                state_reg <= ST_DET;
                            end
                        end
                        else
                        begin
                            step_reg  <= step_reg + 4'd1;
                            state_reg <= ST_DET;
                        end
                    end
                end
                ST_SIGN:
                begin
                    num_reg  <= {nt, {FracBits{1'b0}}};
                    den_reg  <= abs_a;
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    qcnt_reg <= '0;
                    if (pre_ok)
                        state_reg <= ST_DIV;
                    else
                    begin
                        out_hit_reg <= 1'b0;
                        state_reg   <= ST_DONE;
                    end
                end
                ST_DIV:
                begin
                    num_reg <= num_reg << 1;
                    if (!rem_try[DW+1])
                    begin
                        rem_reg <= rem_try[DW:0];
                        quo_reg <= {quo_reg[NW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[NW-2:0], 1'b0};
                    end
                    qcnt_reg <= qcnt_reg + 1'b1;
                    if (qcnt_reg == QCW'(NW - 1))
                    begin
                        out_hit_reg <= 1'b1;   // resolved against best in ST_DONE
                        state_reg   <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        if (out_hit_reg && tq != '0 && tq < cur_best)
                        begin
                            closest_t_reg    <= tq;
                            closest_face_reg <= face_reg;
                            out_t_reg        <= tq;
                            out_face_reg     <= face_reg;
                            out_hit_reg      <= 1'b1;
                        end
                        else
                        begin
                            closest_t_reg <= cur_best;
                            out_t_reg     <= cur_best;
                            out_face_reg  <= closest_face_reg;
                            out_hit_reg   <= 1'b0;
                        end
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OW'({out_face_reg, out_t_reg});
    assign m_axis_tuser  = out_hit_reg;
endmodule

// ===== rtl/rtch_serial_mul.sv =====
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add.
// Uses rtch_pkg.
module rtch_serial_mul #(
    parameter int AW = 64,
    parameter int BW = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic                 done,
    output logic signed [AW+BW-1:0] p
);
    import rtch_pkg::*;
    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic signed [PW-1:0] acc_reg;
    logic signed [PW-1:0] mcand_reg;
    logic [BW-1:0]        mplier_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg   <= 1'b1;
                cnt_reg    <= '0;
                acc_reg    <= '0;
                mcand_reg  <= PW'(a);
                mplier_reg <= b;
            end
            else if (busy_reg)
            begin
                // top bit of a two's complement multiplier has negative weight
                if (mplier_reg[0])
                begin
                    if (cnt_reg == CW'(BW - 1))
                        acc_reg <= acc_reg - mcand_reg;
                    else
                        acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg  <= mcand_reg <<< 1;
                mplier_reg <= mplier_reg >> 1;
                cnt_reg    <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(BW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;
endmodule

// ===== rtl/rtch_port_checker.sv =====
// Port-level checker for the closest-hit core, bound to the top level.
// Uses assert_macros.svh.
`include "assert_macros.svh"
module rtch_port_checker #(
    parameter int TW = 32,
    parameter int OW = 48
) (
    input logic          clk,
    input logic          rst_n,
    input logic          s_axis_tvalid,
    input logic          s_axis_tready,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [OW-1:0] m_axis_tdata,
    input logic          m_axis_tuser
);
    `ASSERT_NEXT(a_no_back_to_back, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken twice in a row")
    `ASSERT_IMPL(a_t_positive, clk, rst_n, m_axis_tvalid, !m_axis_tdata[TW-1], "best t negative")
    `ASSERT_IMPL(a_hit_nonzero, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[TW-1:0] != '0, "hit with zero t")
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
endmodule

bind ray_triangle_closest_hit_core rtch_port_checker #(
    .TW(COORD_WIDTH),
    .OW(((COORD_WIDTH + FACE_ID_WIDTH + 7) / 8) * 8)
) u_rtch_port_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
